FILE: src/csc_pkg.sv
// Shared types, codes and helper functions for the clock setting controller.
// No dependencies; used by csc_cfg, csc_core and clock_setting_controller.
package csc_pkg;

  // Width of the configuration data bus and of the register address
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned DUTY_W = 8;

  // Register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_LONG_PRESS = 3'd0;
  localparam logic [2:0] REG_CONFIRM    = 3'd1;
  localparam logic [2:0] REG_HOUR_DUTY  = 3'd2;
  localparam logic [2:0] REG_MIN_DUTY   = 3'd3;
  localparam logic [2:0] REG_SEC_DUTY   = 3'd4;
  localparam logic [2:0] REG_MARK_DUTY  = 3'd5;

  // Register reset values
  localparam logic [THR_W-1:0]  LONG_PRESS_RST = 16'd1000;
  localparam logic [THR_W-1:0]  CONFIRM_RST    = 16'd50;
  localparam logic [DUTY_W-1:0] HOUR_DUTY_RST  = 8'd255;
  localparam logic [DUTY_W-1:0] MIN_DUTY_RST   = 8'd80;
  localparam logic [DUTY_W-1:0] SEC_DUTY_RST   = 8'd10;
  localparam logic [DUTY_W-1:0] MARK_DUTY_RST  = 8'd5;

  // Output mode codes
  localparam logic [1:0] MODE_CODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_CODE_HOUR   = 2'd1;
  localparam logic [1:0] MODE_CODE_MINUTE = 2'd2;

  // Encoder lamp colours
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_BLUE  = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;

  // Encoder step codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_CCW  = 2'd2;

  // Clock arithmetic limits
  localparam logic [3:0] HOUR_LAST   = 4'd11;
  localparam logic [3:0] HOURS       = 4'd12;
  localparam logic [5:0] MINUTE_LAST = 6'd59;
  localparam logic [5:0] MINUTES     = 6'd60;

  // Display mode, one-hot
  typedef enum logic [2:0] {
    ST_NORMAL = 3'b001,
    ST_HOUR   = 3'b010,
    ST_MINUTE = 3'b100
  } mode_t;

  // Thresholds used by the core
  typedef struct packed {
    logic [THR_W-1:0] long_press;
    logic [THR_W-1:0] confirm;
  } thr_t;

  // One tick from the input stream
  typedef struct packed {
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [3:0] now_hour;
    logic [1:0] rotation;
    logic       switch_pressed;
  } tick_t;

  // One result item
  typedef struct packed {
    logic [5:0] write_minute;
    logic [3:0] write_hour;
    logic       write_time;
    logic [5:0] second_pos;
    logic [5:0] minute_pos;
    logic [5:0] hour_pos;
    logic [1:0] encoder_led;
    logic [1:0] mode;
  } result_t;

  // Fold a raw hour into 0..11
  function automatic logic [3:0] wrap_hour(input logic [3:0] h);
    return (h >= HOURS) ? h - HOURS : h;
  endfunction

  // Fold a raw minute or second into 0..59
  function automatic logic [5:0] wrap_sixty(input logic [5:0] m);
    return (m >= MINUTES) ? m - MINUTES : m;
  endfunction

  // Ring index of the hour marker: hour times five
  function automatic logic [5:0] hour_ring(input logic [3:0] h);
    return 6'({h, 2'b00}) + 6'(h);
  endfunction

endpackage

FILE: src/clock_setting_controller.sv
// Top level of the clock setting controller: stream ports, APB registers, core.
// Depends on csc_pkg, csc_cfg and csc_core.

// One tick per clock cycle is taken at full rate, as long as m_tready does not
// stall the output. Each tick passes the input register and then the result
// register before its result is offered on m_tvalid, and m_tready low holds
// the pipeline without loss. The long-press and confirm thresholds compare for
// equality against a hold counter of HOLD_WIDTH bits that saturates while the
// switch is held. The duty registers are stored and read back only; marker
// compositing and PWM are done downstream. Configure only while no tick is in
// flight.
module clock_setting_controller #(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Tick stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] switch_pressed, [2:1] rotation, [6:3] now_hour, [12:7] now_minute,
  // [18:13] now_second, [23:19] zero
  input  logic [23:0] s_tdata,
  // Result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] mode, [3:2] encoder_led, [9:4] hour_pos, [15:10] minute_pos,
  // [21:16] second_pos, [22] write_time, [26:23] write_hour,
  // [32:27] write_minute, [39:33] zero
  output logic [39:0] m_tdata
);

  csc_pkg::thr_t    thr;
  csc_pkg::tick_t   tick;
  csc_pkg::result_t item;

  csc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // Unpack the incoming transfer
  assign tick = s_tdata[$bits(csc_pkg::tick_t)-1:0];

  csc_core #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .thr       (thr),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_tick   (tick),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (item)
  );

  // Pack the result, zero fill to a whole byte
  assign m_tdata = 40'(item);

endmodule

FILE: src/csc_cfg.sv
// Configuration register file behind an APB-style port.
// Depends on csc_pkg for register indexes, reset values and the threshold struct.
module csc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csc_pkg::ADDR_W-1:0]   paddr,
  input  logic [csc_pkg::DATA_W-1:0]   pwdata,
  output logic [csc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output csc_pkg::thr_t                thr
);

  logic [csc_pkg::THR_W-1:0]  long_press;
  logic [csc_pkg::THR_W-1:0]  confirm;
  logic [csc_pkg::DUTY_W-1:0] hour_duty;
  logic [csc_pkg::DUTY_W-1:0] minute_duty;
  logic [csc_pkg::DUTY_W-1:0] second_duty;
  logic [csc_pkg::DUTY_W-1:0] mark_duty;
  logic [2:0]                 index;
  logic                       wr_en;

  assign pready = 1'b1;
  assign index  = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;

  // Write on the access cycle of a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press  <= csc_pkg::LONG_PRESS_RST;
      confirm     <= csc_pkg::CONFIRM_RST;
      hour_duty   <= csc_pkg::HOUR_DUTY_RST;
      minute_duty <= csc_pkg::MIN_DUTY_RST;
      second_duty <= csc_pkg::SEC_DUTY_RST;
      mark_duty   <= csc_pkg::MARK_DUTY_RST;
    end else if (wr_en) begin
      case (index)
        csc_pkg::REG_LONG_PRESS: long_press  <= pwdata[csc_pkg::THR_W-1:0];
        csc_pkg::REG_CONFIRM:    confirm     <= pwdata[csc_pkg::THR_W-1:0];
        csc_pkg::REG_HOUR_DUTY:  hour_duty   <= pwdata[csc_pkg::DUTY_W-1:0];
        csc_pkg::REG_MIN_DUTY:   minute_duty <= pwdata[csc_pkg::DUTY_W-1:0];
        csc_pkg::REG_SEC_DUTY:   second_duty <= pwdata[csc_pkg::DUTY_W-1:0];
        csc_pkg::REG_MARK_DUTY:  mark_duty   <= pwdata[csc_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (index)
      csc_pkg::REG_LONG_PRESS: prdata = csc_pkg::DATA_W'(long_press);
      csc_pkg::REG_CONFIRM:    prdata = csc_pkg::DATA_W'(confirm);
      csc_pkg::REG_HOUR_DUTY:  prdata = csc_pkg::DATA_W'(hour_duty);
      csc_pkg::REG_MIN_DUTY:   prdata = csc_pkg::DATA_W'(minute_duty);
      csc_pkg::REG_SEC_DUTY:   prdata = csc_pkg::DATA_W'(second_duty);
      csc_pkg::REG_MARK_DUTY:  prdata = csc_pkg::DATA_W'(mark_duty);
      default:                 prdata = '0;
    endcase
  end

  assign thr.long_press = long_press;
  assign thr.confirm    = confirm;

endmodule

FILE: src/csc_core.sv
// Tick pipeline: input register, hold counter and mode state, result register.
// Depends on csc_pkg for the mode enum, codes, item structs and clock helpers.
module csc_core #(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  csc_pkg::thr_t    thr,
  input  logic             in_valid,
  output logic             in_ready,
  input  csc_pkg::tick_t   in_tick,
  output logic             out_valid,
  input  logic             out_ready,
  output csc_pkg::result_t out_item
);

  // Compare width covers both the counter and the 16-bit thresholds
  localparam int unsigned CMP_W = (HOLD_WIDTH > csc_pkg::THR_W) ? HOLD_WIDTH : csc_pkg::THR_W;

  logic                  tick_valid;
  csc_pkg::tick_t        tick;
  logic                  advance;

  csc_pkg::mode_t        mode;
  csc_pkg::mode_t        mode_next;
  logic [HOLD_WIDTH-1:0] hold_count;
  logic [HOLD_WIDTH-1:0] hold_count_next;
  logic [3:0]            edit_hour;
  logic [3:0]            edit_hour_next;
  logic [5:0]            edit_minute;
  logic [5:0]            edit_minute_next;
  csc_pkg::result_t      result_next;

  logic [3:0]            now_h;
  logic [5:0]            now_m;
  logic [5:0]            now_s;
  logic                  hit_long;
  logic                  hit_confirm;
  logic                  commit;

  // Move the held tick into the result register when that slot frees up
  assign advance  = tick_valid & (~out_valid | out_ready);
  assign in_ready = ~tick_valid | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      tick <= in_tick;
    end
  end

  // Normalise the clock time
  assign now_h = csc_pkg::wrap_hour(tick.now_hour);
  assign now_m = csc_pkg::wrap_sixty(tick.now_minute);
  assign now_s = csc_pkg::wrap_sixty(tick.now_second);

  // Hold counter: saturate while pressed, clear on release
  always_comb begin
    if (!tick.switch_pressed) begin
      hold_count_next = '0;
    end else if (hold_count == {HOLD_WIDTH{1'b1}}) begin
      hold_count_next = hold_count;
    end else begin
      hold_count_next = hold_count + 1'b1;
    end
  end

  assign hit_long    = CMP_W'(hold_count_next) == CMP_W'(thr.long_press);
  assign hit_confirm = CMP_W'(hold_count_next) == CMP_W'(thr.confirm);

  // Mode transition, then the encoder step in the new mode
  always_comb begin
    mode_next        = mode;
    edit_hour_next   = edit_hour;
    edit_minute_next = edit_minute;
    commit           = 1'b0;

    case (mode)
      csc_pkg::ST_HOUR: begin
        if (hit_confirm) mode_next = csc_pkg::ST_MINUTE;
      end
      csc_pkg::ST_MINUTE: begin
        if (hit_confirm) begin
          mode_next = csc_pkg::ST_NORMAL;
          commit    = 1'b1;
        end
      end
      default: begin
        mode_next = csc_pkg::ST_NORMAL;
        if (hit_long) begin
          mode_next        = csc_pkg::ST_HOUR;
          edit_hour_next   = now_h;
          edit_minute_next = now_m;
        end
      end
    endcase

    case (mode_next)
      csc_pkg::ST_HOUR: begin
        if (tick.rotation == csc_pkg::ROT_CW) begin
          edit_hour_next = (edit_hour_next == csc_pkg::HOUR_LAST) ? 4'd0
                                                                  : edit_hour_next + 4'd1;
        end else if (tick.rotation == csc_pkg::ROT_CCW) begin
          edit_hour_next = (edit_hour_next == 4'd0) ? csc_pkg::HOUR_LAST
                                                    : edit_hour_next - 4'd1;
        end
      end
      csc_pkg::ST_MINUTE: begin
        if (tick.rotation == csc_pkg::ROT_CW) begin
          edit_minute_next = (edit_minute_next == csc_pkg::MINUTE_LAST) ? 6'd0
                                                                        : edit_minute_next + 6'd1;
        end else if (tick.rotation == csc_pkg::ROT_CCW) begin
          edit_minute_next = (edit_minute_next == 6'd0) ? csc_pkg::MINUTE_LAST
                                                        : edit_minute_next - 6'd1;
        end
      end
      default: ;
    endcase
  end

  // Form the result in the new mode
  always_comb begin
    case (mode_next)
      csc_pkg::ST_HOUR: begin
        result_next.mode        = csc_pkg::MODE_CODE_HOUR;
        result_next.encoder_led = csc_pkg::LED_BLUE;
      end
      csc_pkg::ST_MINUTE: begin
        result_next.mode        = csc_pkg::MODE_CODE_MINUTE;
        result_next.encoder_led = csc_pkg::LED_GREEN;
      end
      default: begin
        result_next.mode        = csc_pkg::MODE_CODE_NORMAL;
        result_next.encoder_led = csc_pkg::LED_OFF;
      end
    endcase

    if (mode_next == csc_pkg::ST_NORMAL) begin
      result_next.hour_pos   = csc_pkg::hour_ring(now_h);
      result_next.minute_pos = now_m;
      result_next.second_pos = now_s;
    end else begin
      result_next.hour_pos   = csc_pkg::hour_ring(edit_hour_next);
      result_next.minute_pos = edit_minute_next;
      result_next.second_pos = 6'd0;
    end

    // On commit the edit registers are left untouched by the step
    result_next.write_time   = commit;
    result_next.write_hour   = commit ? edit_hour : 4'd0;
    result_next.write_minute = commit ? edit_minute : 6'd0;
  end

  // Controller state, updated once per transferred tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= csc_pkg::ST_NORMAL;
      hold_count  <= '0;
      edit_hour   <= 4'd0;
      edit_minute <= 6'd0;
    end else if (advance) begin
      mode        <= mode_next;
      hold_count  <= hold_count_next;
      edit_hour   <= edit_hour_next;
      edit_minute <= edit_minute_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item <= result_next;
    end
  end

endmodule

FILE: verif/clock_setting_controller_test.sv
// Self-checking testbench for clock_setting_controller: tick stream in, result stream out.
// Depends on csc_pkg and the RTL below src/; a built-in predictor checks every result.
`timescale 1ns / 100ps

module clock_setting_controller_test;

  localparam int HOLD_W = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REG_COUNT = 6;
  localparam int REPORT_LIMIT = 10;
  // Encoder code with no meaning; the block must treat it as no step
  localparam logic [1:0] ROT_UNUSED = 2'd3;

  // One row of the directed stimulus
  typedef struct packed {
    csc_pkg::tick_t   tick;
    logic             typed;
    logic             reconfig;
    csc_pkg::result_t view;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [0] switch_pressed, [2:1] rotation, [6:3] now_hour, [12:7] now_minute,
  // [18:13] now_second, [23:19] zero
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [1:0] mode, [3:2] encoder_led, [9:4] hour_pos, [15:10] minute_pos,
  // [21:16] second_pos, [22] write_time, [26:23] write_hour, [32:27] write_minute
  logic [39:0] m_tdata;

  // Predictor state and register copies
  logic [1:0]        mode_now = csc_pkg::MODE_CODE_NORMAL;
  logic [HOLD_W-1:0] held_ticks = '0;
  logic [3:0]        set_hour = '0;
  logic [5:0]        set_minute = '0;
  logic [31:0]       reg_shadow [REG_COUNT];

  csc_pkg::result_t pending_views [$];
  stim_row_t        stim_rows [$];
  int          mismatches = 0;
  int          ticks_sent = 0;
  int          views_seen = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  logic        quiet = 1'b0;

  clock_setting_controller #(.HOLD_WIDTH(HOLD_W)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length for either side: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Advance the predictor by one tick and return the display it should give
  function automatic csc_pkg::result_t predict_tick(input csc_pkg::tick_t t);
    logic [3:0]       rtc_hour;
    logic [5:0]       rtc_minute;
    logic [5:0]       rtc_second;
    logic             commit;
    csc_pkg::result_t view;
    rtc_hour   = t.now_hour % csc_pkg::HOURS;
    rtc_minute = t.now_minute % csc_pkg::MINUTES;
    rtc_second = t.now_second % csc_pkg::MINUTES;
    commit     = 1'b0;

    // count the hold, stopping at full scale; release clears it
    if (t.switch_pressed) begin
      if (held_ticks != '1) held_ticks++;
    end else begin
      held_ticks = '0;
    end

    // transitions fire only when the count equals the threshold
    case (mode_now)
      csc_pkg::MODE_CODE_HOUR: begin
        if (held_ticks == reg_shadow[csc_pkg::REG_CONFIRM][HOLD_W-1:0])
          mode_now = csc_pkg::MODE_CODE_MINUTE;
      end
      csc_pkg::MODE_CODE_MINUTE: begin
        if (held_ticks == reg_shadow[csc_pkg::REG_CONFIRM][HOLD_W-1:0]) begin
          mode_now = csc_pkg::MODE_CODE_NORMAL;
          commit   = 1'b1;
        end
      end
      default: begin
        mode_now = csc_pkg::MODE_CODE_NORMAL;
        if (held_ticks == reg_shadow[csc_pkg::REG_LONG_PRESS][HOLD_W-1:0]) begin
          mode_now   = csc_pkg::MODE_CODE_HOUR;
          set_hour   = rtc_hour;
          set_minute = rtc_minute;
        end
      end
    endcase

    // the encoder steps whichever field the new mode edits
    if (mode_now == csc_pkg::MODE_CODE_HOUR) begin
      if (t.rotation == csc_pkg::ROT_CW)
        set_hour = (set_hour == csc_pkg::HOUR_LAST) ? 4'd0 : set_hour + 4'd1;
      else if (t.rotation == csc_pkg::ROT_CCW)
        set_hour = (set_hour == 4'd0) ? csc_pkg::HOUR_LAST : set_hour - 4'd1;
    end else if (mode_now == csc_pkg::MODE_CODE_MINUTE) begin
      if (t.rotation == csc_pkg::ROT_CW)
        set_minute = (set_minute == csc_pkg::MINUTE_LAST) ? 6'd0 : set_minute + 6'd1;
      else if (t.rotation == csc_pkg::ROT_CCW)
        set_minute = (set_minute == 6'd0) ? csc_pkg::MINUTE_LAST : set_minute - 6'd1;
    end

    view = '0;
    view.mode = mode_now;
    case (mode_now)
      csc_pkg::MODE_CODE_HOUR:   view.encoder_led = csc_pkg::LED_BLUE;
      csc_pkg::MODE_CODE_MINUTE: view.encoder_led = csc_pkg::LED_GREEN;
      default:                   view.encoder_led = csc_pkg::LED_OFF;
    endcase
    if (mode_now == csc_pkg::MODE_CODE_NORMAL) begin
      view.hour_pos   = 6'(rtc_hour) * 6'd5;
      view.minute_pos = rtc_minute;
      view.second_pos = rtc_second;
    end else begin
      view.hour_pos   = 6'(set_hour) * 6'd5;
      view.minute_pos = set_minute;
    end
    if (commit) begin
      view.write_time   = 1'b1;
      view.write_hour   = set_hour;
      view.write_minute = set_minute;
    end
    return view;
  endfunction

  // Random tick: rotations favoured, RTC values now and then past their range
  function automatic csc_pkg::tick_t random_tick(input logic level);
    csc_pkg::tick_t t;
    int unsigned    r;
    logic           wide;
    r    = $urandom_range(0, 7);
    wide = ($urandom_range(0, 4) == 0);
    t.switch_pressed = level;
    if (r < 3) t.rotation = csc_pkg::ROT_CW;
    else if (r < 6) t.rotation = csc_pkg::ROT_CCW;
    else if (r == 6) t.rotation = csc_pkg::ROT_NONE;
    else t.rotation = ROT_UNUSED;
    t.now_hour   = 4'($urandom_range(0, wide ? 15 : 11));
    t.now_minute = 6'($urandom_range(0, wide ? 63 : 59));
    t.now_second = 6'($urandom_range(0, wide ? 63 : 59));
    return t;
  endfunction

  // Press length for a threshold: mostly exact or a little over, sometimes short; above 40, a random 1 to 40
  function automatic int press_len(input logic [31:0] thr);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (thr > 40) return $urandom_range(1, 40);
    if (r == 0 && thr > 0) return $urandom_range(0, thr - 1);
    if (r < 6) return thr;
    return thr + $urandom_range(1, 3);
  endfunction

  function automatic csc_pkg::result_t normal_view(input logic [5:0] hp, mp, sp);
    csc_pkg::result_t view;
    view = '0;
    view.mode        = csc_pkg::MODE_CODE_NORMAL;
    view.encoder_led = csc_pkg::LED_OFF;
    view.hour_pos    = hp;
    view.minute_pos  = mp;
    view.second_pos  = sp;
    return view;
  endfunction

  function automatic stim_row_t mk_row(input logic p, input logic [1:0] rot,
                                       input logic [3:0] h, input logic [5:0] m, s,
                                       input logic typed, reconfig,
                                       input csc_pkg::result_t view);
    stim_row_t row;
    row.tick.switch_pressed = p;
    row.tick.rotation       = rot;
    row.tick.now_hour       = h;
    row.tick.now_minute     = m;
    row.tick.now_second     = s;
    row.typed               = typed;
    row.reconfig            = reconfig;
    row.view                = view;
    return row;
  endfunction

  // Offer one tick and hold it until the transfer; record what it should show
  task automatic send_tick(input csc_pkg::tick_t t, input logic typed,
                           input csc_pkg::result_t typed_view);
    int               gap;
    csc_pkg::result_t want;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_tick(t);
    if (typed) want = typed_view;
    pending_views.push_back(want);
    ticks_sent++;
  endtask

  task automatic hold_switch(input int n, input logic level);
    repeat (n) send_tick(random_tick(level), 1'b0, '0);
  endtask

  // Stop offering ticks and wait until every expected result is back
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("register %0d read back: expected %0h, got %0h", idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    for (int i = 0; i < REG_COUNT; i++) apb_read(3'(i), reg_shadow[i]);
  endtask

  // Drain, write every register, then read them all back
  task automatic apply_config(input logic [15:0] long_press, confirm,
                              input logic [7:0] hour_d, minute_d, second_d, mark_d);
    logic [31:0] vals [REG_COUNT];
    settle_idle();
    vals[csc_pkg::REG_LONG_PRESS] = 32'(long_press);
    vals[csc_pkg::REG_CONFIRM]    = 32'(confirm);
    vals[csc_pkg::REG_HOUR_DUTY]  = 32'(hour_d);
    vals[csc_pkg::REG_MIN_DUTY]   = 32'(minute_d);
    vals[csc_pkg::REG_SEC_DUTY]   = 32'(second_d);
    vals[csc_pkg::REG_MARK_DUTY]  = 32'(mark_d);
    for (int i = 0; i < REG_COUNT; i++) begin
      apb_write(3'(i), vals[i]);
      reg_shadow[i] = vals[i];
    end
    check_registers();
  endtask

  task automatic random_duties(input logic [15:0] long_press, confirm);
    apply_config(long_press, confirm, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Mostly full set-and-commit sequences with random content, some noise
  task automatic run_phase(input int budget);
    int start;
    int pick;
    start = ticks_sent;
    while (ticks_sent - start < budget) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick  = $urandom_range(0, 19);
      if (pick == 0) begin
        settle_idle();
      end else if (pick < 5) begin
        hold_switch($urandom_range(0, 8), 1'b1);
        hold_switch($urandom_range(1, 4), 1'b0);
      end else begin
        hold_switch(press_len(reg_shadow[csc_pkg::REG_LONG_PRESS]), 1'b1);
        hold_switch($urandom_range(1, 6), 1'b0);
        hold_switch(press_len(reg_shadow[csc_pkg::REG_CONFIRM]), 1'b1);
        hold_switch($urandom_range(1, 6), 1'b0);
        hold_switch(press_len(reg_shadow[csc_pkg::REG_CONFIRM]), 1'b1);
        hold_switch($urandom_range(1, 4), 1'b0);
      end
    end
    quiet = 1'b0;
  endtask

  // Result side: random stalls, compare each transfer, watch for a hang
  initial begin
    csc_pkg::result_t got;
    csc_pkg::result_t want;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst) begin
        if (m_tvalid && m_tready) begin
          got = m_tdata[32:0];
          views_seen++;
          if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d arrived with nothing pending: %p", views_seen, got);
          end else begin
            want = pending_views.pop_front();
            if (got !== want) begin
              mismatches++;
              if (mismatches <= REPORT_LIMIT)
                $display({"result %0d (exp/got): mode %0d/%0d led %0d/%0d hour %0d/%0d ",
                          "min %0d/%0d sec %0d/%0d wr %0d/%0d wh %0d/%0d wm %0d/%0d"},
                         views_seen, want.mode, got.mode, want.encoder_led, got.encoder_led,
                         want.hour_pos, got.hour_pos, want.minute_pos, got.minute_pos,
                         want.second_pos, got.second_pos, want.write_time, got.write_time,
                         want.write_hour, got.write_hour, want.write_minute, got.write_minute);
            end
          end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
        else quiet_cycles++;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus: reset, directed rows, then phases of random sequences
  initial begin
    reg_shadow[csc_pkg::REG_LONG_PRESS] = 32'(csc_pkg::LONG_PRESS_RST);
    reg_shadow[csc_pkg::REG_CONFIRM]    = 32'(csc_pkg::CONFIRM_RST);
    reg_shadow[csc_pkg::REG_HOUR_DUTY]  = 32'(csc_pkg::HOUR_DUTY_RST);
    reg_shadow[csc_pkg::REG_MIN_DUTY]   = 32'(csc_pkg::MIN_DUTY_RST);
    reg_shadow[csc_pkg::REG_SEC_DUTY]   = 32'(csc_pkg::SEC_DUTY_RST);
    reg_shadow[csc_pkg::REG_MARK_DUTY]  = 32'(csc_pkg::MARK_DUTY_RST);

    // reset thresholds: no press gets near the long press, so the RTC time shows
    stim_rows.push_back(mk_row(0, csc_pkg::ROT_NONE, 0, 0, 0, 1, 0, normal_view(0, 0, 0)));
    stim_rows.push_back(mk_row(0, csc_pkg::ROT_CW, 11, 59, 59, 1, 0, normal_view(55, 59, 59)));
    stim_rows.push_back(mk_row(1, csc_pkg::ROT_CCW, 12, 60, 60, 1, 0, normal_view(0, 0, 0)));
    stim_rows.push_back(mk_row(1, ROT_UNUSED, 15, 63, 63, 1, 0, normal_view(15, 3, 3)));
    stim_rows.push_back(mk_row(0, csc_pkg::ROT_NONE, 5, 30, 45, 1, 0, normal_view(25, 30, 45)));
    stim_rows.push_back(mk_row(1, csc_pkg::ROT_CW, 10, 21, 42, 1, 0, normal_view(50, 21, 42)));
    stim_rows.push_back(mk_row(1, csc_pkg::ROT_CCW, 5, 42, 21, 1, 0, normal_view(25, 42, 21)));
    stim_rows.push_back(mk_row(0, csc_pkg::ROT_NONE, 8, 32, 16, 1, 0, normal_view(40, 32, 16)));
    // short thresholds: enter on the second press tick with a step on that tick
    stim_rows.push_back(mk_row(1, csc_pkg::ROT_CW, 11, 59, 0, 0, 1, '0));
    stim_rows.push_back(mk_row(1, csc_pkg::ROT_CW, 3, 1, 7, 0, 0, '0));
    stim_rows.push_back(mk_row(1, csc_pkg::ROT_NONE, 7, 7, 7, 0, 0, '0));
    // step the hour down through zero and back up
    repeat (5) stim_rows.push_back(mk_row(0, csc_pkg::ROT_CCW, 2, 20, 30, 0, 0, '0));
    stim_rows.push_back(mk_row(0, csc_pkg::ROT_CW, 2, 20, 30, 0, 0, '0));
    // confirm into minute setting, step the minute through zero
    stim_rows.push_back(mk_row(1, csc_pkg::ROT_CW, 6, 6, 6, 0, 0, '0));
    repeat (3) stim_rows.push_back(mk_row(0, csc_pkg::ROT_CCW, 6, 6, 6, 0, 0, '0));
    stim_rows.push_back(mk_row(0, csc_pkg::ROT_CW, 6, 6, 6, 0, 0, '0));
    // commit: normal mode with the incoming RTC time and the edited time written
    stim_rows.push_back(mk_row(1, ROT_UNUSED, 9, 17, 33, 0, 0, '0));
    stim_rows.push_back(mk_row(0, csc_pkg::ROT_NONE, 9, 17, 34, 0, 0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_registers();

    foreach (stim_rows[i]) begin
      if (stim_rows[i].reconfig) apply_config(16'd2, 16'd1, 8'd255, 8'd0, 8'd128, 8'd64);
      send_tick(stim_rows[i].tick, stim_rows[i].typed, stim_rows[i].view);
    end

    apply_config(16'd3, 16'd2, 8'd0, 8'd255, 8'd0, 8'd255);
    run_phase(80);
    apply_config(16'd1, 16'd1, 8'd255, 8'd0, 8'd255, 8'd0);
    run_phase(110);
    // zero thresholds match on released ticks
    apply_config(16'd0, 16'd0, 8'd1, 8'd254, 8'd128, 8'd127);
    run_phase(90);
    // a confirm that a short press never reaches
    random_duties(16'd2, 16'hFFFF);
    run_phase(60);
    repeat (3) begin
      random_duties(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)));
      run_phase(130);
    end
    // long hold: the count is already past confirm on entry, so only equality fires
    random_duties(16'd60, 16'd20);
    hold_switch(80, 1'b1);
    hold_switch(3, 1'b0);
    run_phase(30);

    settle_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_views.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
